// ----- rtl/swm_pkg.sv -----
// shared types and constants for the sliding window median filter
`default_nettype none
package swm_pkg;

    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] LEN_RESET = 7'd3;

    typedef struct packed {
        logic clr;
        logic upd;
        logic rem;
    } cell_ctrl_t;

    typedef struct packed {
        logic cv;
        logic le;
    } cell_link_t;

endpackage
`default_nettype wire

// ----- rtl/swm_ram.sv -----
// generic single write port ram with registered read
`default_nettype none
module swm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                  aclk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- rtl/swm_cell.sv -----
// one compare and shift cell of the sorted window chain
`default_nettype none
module swm_cell #(
    parameter int KEY_W = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire swm_pkg::cell_ctrl_t   ctrl,
    input  wire logic [KEY_W-1:0]      new_key,
    input  wire logic [KEY_W-1:0]      rem_key,
    input  wire logic [KEY_W-1:0]      below_ck,
    input  wire swm_pkg::cell_link_t   below,
    input  wire logic [KEY_W-1:0]      above_key,
    input  wire logic                  above_valid,
    output logic      [KEY_W-1:0]      key,
    output logic                       valid,
    output logic      [KEY_W-1:0]      ck,
    output swm_pkg::cell_link_t        link
);
    import swm_pkg::*;

    logic [KEY_W-1:0] key_reg, key_next;
    logic             valid_reg, valid_next;
    logic             shift;
    logic [KEY_W-1:0] ck_w;
    cell_link_t       link_w;

    // compacted view after the oldest entry is taken out
    assign shift     = ctrl.rem && valid_reg && (key_reg >= rem_key);
    assign ck_w      = shift ? above_key : key_reg;
    assign link_w.cv = ctrl.rem ? above_valid : valid_reg;
    assign link_w.le = link_w.cv && (ck_w <= new_key);

    always_comb begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (ctrl.upd) begin
            if (link_w.le) begin
                key_next = ck_w;
            end else if (below.le) begin
                key_next = new_key;
            end else begin
                key_next = below_ck;
            end
            valid_next = link_w.cv || below.cv;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.clr) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

    assign key   = key_reg;
    assign valid = valid_reg;
    assign ck    = ck_w;
    assign link  = link_w;

endmodule
`default_nettype wire

// ----- rtl/sliding_window_median.sv -----
// sliding window median filter top level
//
// input channel s_valid/s_ready carries one signed sample and a start flag per request;
// start_stream empties the window before the sample enters it.
// result channel m_valid/m_ready carries the lower median of the full window.
// no result is given while the window is filling.
// window length is set through cfg_wr_en/cfg_wr_data; the user writes it only while
// idle, which the block itself does not enforce. a write also empties the window.
// zero means one, values above WINDOW_MAX saturate. each request passes through
// accept (arrival ram read of the oldest sample), chain update (every cell compares
// and shifts in parallel, ram write) and result load; requests that give no result
// skip the result load. m_valid rises as the result is loaded into a free output register.
// the result sits in an output register; a new request is accepted while it
// waits, and the result load holds the next request until the register frees.
// reset sets the window length to three and empties the window; no clearing
// pass is needed.
`default_nettype none
module sliding_window_median #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [SAMPLE_BITS-1:0] s_sample,
    input  wire logic                   s_start_stream,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic      [SAMPLE_BITS-1:0] m_median,
    input  wire logic                   cfg_wr_en,
    input  wire logic [swm_pkg::CFG_W-1:0] cfg_wr_data
);
    import swm_pkg::*;

    localparam int IDX_W = WINDOW_MAX > 1 ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int EXT_W = CNT_W > CFG_W ? CNT_W : CFG_W;
    localparam logic [SAMPLE_BITS-1:0] SIGN_BIT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_UPD  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [CFG_W-1:0]       cfg_len_reg;
    logic [CNT_W-1:0]       fill_reg, fill_next;
    logic [IDX_W-1:0]       optr_reg, optr_next;
    logic [SAMPLE_BITS-1:0] key_reg;
    logic                   full_reg;
    logic [IDX_W-1:0]       slot_reg;
    logic                   m_valid_reg;
    logic [SAMPLE_BITS-1:0] m_median_reg;

    logic                   acc;
    logic [EXT_W-1:0]       len_ext, len_wide;
    logic [CNT_W-1:0]       len_eff;
    logic [CNT_W:0]         len_p1;
    logic [CNT_W-1:0]       mid_cnt;
    logic [IDX_W-1:0]       mid_idx;
    logic [CNT_W-1:0]       fill_eff;
    logic [IDX_W-1:0]       optr_eff;
    logic                   full_a;
    logic [CNT_W-1:0]       fill_inc;
    logic [CNT_W-1:0]       optr_inc;
    logic                   produce;
    logic                   out_free;
    logic [SAMPLE_BITS-1:0] rem_key;
    cell_ctrl_t             ctrl;

    logic [SAMPLE_BITS-1:0] cell_key [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] cell_ck  [WINDOW_MAX];
    cell_link_t             cell_link [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]  cell_valid;

    // effective window length
    assign len_ext = EXT_W'(cfg_len_reg);
    always_comb begin
        if (len_ext == '0) begin
            len_wide = EXT_W'(1);
        end else if (len_ext > EXT_W'(WINDOW_MAX)) begin
            len_wide = EXT_W'(WINDOW_MAX);
        end else begin
            len_wide = len_ext;
        end
    end
    assign len_eff = len_wide[CNT_W-1:0];
    assign len_p1  = {1'b0, len_eff} + (CNT_W+1)'(1);
    assign mid_cnt = len_p1[CNT_W:1] - CNT_W'(1);
    assign mid_idx = mid_cnt[IDX_W-1:0];

    assign s_ready  = (state_reg == ST_IDLE);
    assign acc      = s_valid && s_ready;
    assign fill_eff = s_start_stream ? '0 : fill_reg;
    assign optr_eff = s_start_stream ? '0 : optr_reg;
    assign full_a   = (fill_eff == len_eff);
    assign fill_inc = fill_reg + CNT_W'(1);
    assign optr_inc = CNT_W'(optr_reg) + CNT_W'(1);
    assign produce  = full_reg || (fill_inc == len_eff);
    assign out_free = !m_valid_reg || m_ready;

    assign ctrl.clr = cfg_wr_en || (acc && s_start_stream);
    assign ctrl.upd = (state_reg == ST_UPD);
    assign ctrl.rem = full_reg;

    swm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_arrival (
        .aclk  (aclk),
        .we    (ctrl.upd),
        .waddr (slot_reg),
        .wdata (key_reg),
        .re    (acc),
        .raddr (optr_eff),
        .rdata (rem_key)
    );

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
            cell_link_t             below_link;
            logic [SAMPLE_BITS-1:0] below_ck;
            logic [SAMPLE_BITS-1:0] above_key;
            logic                   above_valid;

            if (gi == 0) begin : g_first
                assign below_link.cv = 1'b1;
                assign below_link.le = 1'b1;
                assign below_ck      = '0;
            end else begin : g_mid
                assign below_link = cell_link[gi-1];
                assign below_ck   = cell_ck[gi-1];
            end

            if (gi == WINDOW_MAX - 1) begin : g_last
                assign above_key   = '0;
                assign above_valid = 1'b0;
            end else begin : g_top
                assign above_key   = cell_key[gi+1];
                assign above_valid = cell_valid[gi+1];
            end

            swm_cell #(
                .KEY_W (SAMPLE_BITS)
            ) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl),
                .new_key     (key_reg),
                .rem_key     (rem_key),
                .below_ck    (below_ck),
                .below       (below_link),
                .above_key   (above_key),
                .above_valid (above_valid),
                .key         (cell_key[gi]),
                .valid       (cell_valid[gi]),
                .ck          (cell_ck[gi]),
                .link        (cell_link[gi])
            );
        end
    endgenerate

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        optr_next  = optr_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    state_next = ST_UPD;
                    fill_next  = fill_eff;
                    optr_next  = optr_eff;
                end
            end
            ST_UPD: begin
                if (full_reg) begin
                    optr_next = (optr_inc == len_eff) ? '0 : optr_inc[IDX_W-1:0];
                end else begin
                    fill_next = fill_inc;
                end
                state_next = produce ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cfg_len_reg <= LEN_RESET;
            fill_reg    <= '0;
            optr_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                cfg_len_reg <= cfg_wr_data;
                fill_reg    <= '0;
                optr_reg    <= '0;
            end else begin
                fill_reg <= fill_next;
                optr_reg <= optr_next;
            end
            if (state_reg == ST_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // request payload and result data
    always_ff @(posedge aclk) begin
        if (acc) begin
            key_reg  <= s_sample ^ SIGN_BIT;
            full_reg <= full_a;
            slot_reg <= full_a ? optr_eff : fill_eff[IDX_W-1:0];
        end
        if (state_reg == ST_EMIT && out_free) begin
            m_median_reg <= cell_key[mid_idx] ^ SIGN_BIT;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_median = m_median_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= len_eff)
        else $error("fill count above window length");

    a_valid_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(cell_valid) == int'(fill_reg))
        else $error("cell valid bits disagree with fill count");

    a_upd_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        acc |=> (state_reg == ST_UPD))
        else $error("accepted request did not reach the chain update");
`endif

endmodule
`default_nettype wire
